// ===== hw/rtl/ljpe_pkg.sv =====
// ----------------------------------------------------------------------------
// ljpe_pkg
// Shared types and constants of the Lennard-Jones pair energy accumulator.
// ----------------------------------------------------------------------------
package ljpe_pkg;

    localparam int MAX_PARTICLES = 4096;
    localparam int ADDR_W        = $clog2(MAX_PARTICLES);
    localparam int INDEX_W       = 12;
    localparam int POS_W         = 32;
    localparam int POS_WORD_W    = 3 * POS_W;
    localparam int RECIP_W       = 49;   // floor(2^48 / r2) needs 49 bits
    localparam int CFG_INDEX_W   = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_CUTOFF_SQ   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEFF_C2    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEFF_C0    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REAL_COUNT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FINAL_HALVE = 3'd4;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PAIR = 1'b1;

    typedef struct packed {
        logic [31:0]        cutoff_sq;
        logic signed [31:0] coeff_c2;
        logic signed [31:0] coeff_c0;
        logic [12:0]        real_count;
        logic               final_halve;
    } ljpe_cfg_t;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] index_a;
        logic [INDEX_W-1:0] index_b;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_z;
        logic               last_pair;
    } ljpe_item_t;

endpackage

// ===== hw/rtl/ljpe_ram.sv =====
// ----------------------------------------------------------------------------
// ljpe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ljpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ljpe_recip.sv =====
// ----------------------------------------------------------------------------
// ljpe_recip
// Bit-serial restoring divider: floor(2^48 / divisor), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ljpe_recip
    import ljpe_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        divisor,
    output logic               done,
    output logic [RECIP_W-1:0] quotient
);

    localparam int CNT_W = $clog2(RECIP_W);

    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        div_reg, div_next;
    logic [RECIP_W-1:0] quo_reg, quo_next;
    logic [32:0]        trial;
    logic [32:0]        diff;
    logic               ge;

    // dividend is a single one at the top bit
    assign trial = {rem_reg, (cnt_reg == CNT_W'(RECIP_W - 1))};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = (trial >= {1'b0, div_reg});

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        if (start) begin
            run_next = 1'b1;
            cnt_next = CNT_W'(RECIP_W - 1);
            rem_next = '0;
            div_next = divisor;
            quo_next = '0;
        end else if (run_reg) begin
            rem_next = ge ? diff[31:0] : trial[31:0];
            quo_next = {quo_reg[RECIP_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/ljpe_core.sv =====
// ----------------------------------------------------------------------------
// ljpe_core
// Position store, pair sequencer, shared multiplier and energy accumulator.
// ----------------------------------------------------------------------------
module ljpe_core
    import ljpe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  ljpe_cfg_t   cfg,
    input  logic        start,
    input  ljpe_item_t  item,
    output logic        idle,
    input  logic        out_free,
    output logic        res_valid,
    output logic [63:0] res_energy,
    output logic        res_sat
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RDB  = 5'd1;
    localparam logic [4:0] S_DIFF = 5'd2;
    localparam logic [4:0] S_SQX  = 5'd3;
    localparam logic [4:0] S_SQY  = 5'd4;
    localparam logic [4:0] S_SQZ  = 5'd5;
    localparam logic [4:0] S_SQS  = 5'd6;
    localparam logic [4:0] S_CMP  = 5'd7;
    localparam logic [4:0] S_DIV  = 5'd8;
    localparam logic [4:0] S_Q    = 5'd9;
    localparam logic [4:0] S_QEND = 5'd10;
    localparam logic [4:0] S_C2   = 5'd11;
    localparam logic [4:0] S_ADD1 = 5'd12;
    localparam logic [4:0] S_ADD2 = 5'd13;
    localparam logic [4:0] S_DBL1 = 5'd14;
    localparam logic [4:0] S_DBL2 = 5'd15;
    localparam logic [4:0] S_ACC  = 5'd16;
    localparam logic [4:0] S_FIN  = 5'd17;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    // {saturated, sum}
    function automatic logic [64:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return {1'b1, (s[64] ? S64_MIN : S64_MAX)};
        end
        return {1'b0, s[63:0]};
    endfunction

    logic [4:0]          state_reg, state_next;
    logic [INDEX_W-1:0]  ib_reg, ib_next;
    logic                last_reg, last_next;
    logic                ghost_reg, ghost_next;
    logic [POS_WORD_W-1:0] pa_reg, pa_next;
    logic [31:0]         dabs_reg [3];
    logic [31:0]         dabs_next [3];
    logic [65:0]         s_reg, s_next;
    logic [31:0]         r2_reg, r2_next;
    logic [63:0]         qa_reg, qa_next;
    logic [63:0]         qb_reg, qb_next;
    logic [127:0]        qacc_reg, qacc_next;
    logic [2:0]          qk_reg, qk_next;
    logic [1:0]          qstep_reg, qstep_next;
    logic [63:0]         inv3_reg, inv3_next;
    logic signed [63:0]  e_reg, e_next;
    logic signed [63:0]  acc_reg, acc_next;
    logic                sat_reg, sat_next;
    logic [63:0]         mul_reg;
    logic                mvalid_reg, mvalid_next;
    logic [1:0]          mshift_reg, mshift_next;
    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  prod;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [POS_WORD_W-1:0] ram_rdata;
    logic                div_start, div_done;
    logic [RECIP_W-1:0]  div_q;

    logic signed [32:0]  dsub [3];
    logic [127:0]        pp_shifted;
    logic                qm_sat;
    logic [63:0]         qm_res;
    logic [64:0]         sa;
    logic signed [63:0]  c2term, c0term, e_acc;
    logic                skip;
    logic signed [63:0]  total;

    ljpe_ram #(
        .WIDTH (POS_WORD_W),
        .DEPTH (MAX_PARTICLES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ADDR_W'(item.index_a)),
        .wdata ({item.pos_z, item.pos_y, item.pos_x}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ljpe_recip u_recip (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (r2_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign ram_we    = start && (item.kind == KIND_LOAD);
    assign ram_raddr = (state_reg == S_IDLE) ? ADDR_W'(item.index_a) : ADDR_W'(ib_reg);

    // position words are {z, y, x}, x lowest
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dsub[i] = {pa_reg[i*POS_W+31], pa_reg[i*POS_W +: POS_W]}
                    - {ram_rdata[i*POS_W+31], ram_rdata[i*POS_W +: POS_W]};
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mvalid_next = 1'b0;
        mshift_next = 2'd0;
        case (state_reg)
            S_SQX: begin
                mul_a = {1'b0, dabs_reg[0]};
                mul_b = {1'b0, dabs_reg[0]};
            end
            S_SQY: begin
                mul_a = {1'b0, dabs_reg[1]};
                mul_b = {1'b0, dabs_reg[1]};
            end
            S_SQZ: begin
                mul_a = {1'b0, dabs_reg[2]};
                mul_b = {1'b0, dabs_reg[2]};
            end
            S_Q: begin
                if (qk_reg != 3'd4) begin
                    mvalid_next = 1'b1;
                    mul_a = {1'b0, (qk_reg[1] ? qa_reg[63:32] : qa_reg[31:0])};
                    mul_b = {1'b0, (qk_reg[1:0] == 2'd1 || qk_reg[1:0] == 2'd3)
                                   ? qb_reg[63:32] : qb_reg[31:0]};
                    mshift_next = (qk_reg[1:0] == 2'd0) ? 2'd0 :
                                  (qk_reg[1:0] == 2'd3) ? 2'd2 : 2'd1;
                end
            end
            S_C2: begin
                mul_a = {cfg.coeff_c2[31], cfg.coeff_c2};
                mul_b = {1'b0, r2_reg};
            end
            default: begin
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb begin
        case (mshift_reg)
            2'd0:    pp_shifted = {64'd0, mul_reg};
            2'd1:    pp_shifted = {32'd0, mul_reg, 32'd0};
            default: pp_shifted = {mul_reg, 64'd0};
        endcase
    end

    assign qm_sat = |qacc_reg[127:95];
    assign qm_res = qm_sat ? 64'(S64_MAX) : qacc_reg[95:32];
    assign skip   = (|s_reg[65:48]) || (s_reg[47:16] > cfg.cutoff_sq);
    assign c2term = $signed(mul_reg) >>> 8;
    assign c0term = {{24{cfg.coeff_c0[31]}}, cfg.coeff_c0, 8'd0};
    assign e_acc  = ghost_reg ? (e_reg >>> 1) : e_reg;
    assign total  = cfg.final_halve ? (acc_reg >>> 1) : acc_reg;

    always_comb begin
        state_next = state_reg;
        ib_next    = ib_reg;
        last_next  = last_reg;
        ghost_next = ghost_reg;
        pa_next    = pa_reg;
        dabs_next  = dabs_reg;
        s_next     = s_reg;
        r2_next    = r2_reg;
        qa_next    = qa_reg;
        qb_next    = qb_reg;
        qacc_next  = qacc_reg;
        qk_next    = qk_reg;
        qstep_next = qstep_reg;
        inv3_next  = inv3_reg;
        e_next     = e_reg;
        acc_next   = acc_reg;
        sat_next   = sat_reg;
        div_start  = 1'b0;
        res_valid  = 1'b0;
        sa         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (start && item.kind == KIND_PAIR) begin
                    ib_next    = item.index_b;
                    last_next  = item.last_pair;
                    ghost_next = ({1'b0, item.index_a} >= cfg.real_count)
                              || ({1'b0, item.index_b} >= cfg.real_count);
                    state_next = S_RDB;
                end
            end
            S_RDB: begin
                pa_next    = ram_rdata;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    dabs_next[i] = dsub[i][32] ? 32'(-dsub[i]) : dsub[i][31:0];
                end
                state_next = S_SQX;
            end
            S_SQX: state_next = S_SQY;
            S_SQY: begin
                s_next     = {2'd0, mul_reg};
                state_next = S_SQZ;
            end
            S_SQZ: begin
                s_next     = s_reg + {2'd0, mul_reg};
                state_next = S_SQS;
            end
            S_SQS: begin
                s_next     = s_reg + {2'd0, mul_reg};
                state_next = S_CMP;
            end
            S_CMP: begin
                r2_next    = s_reg[47:16];
                qacc_next  = '0;
                qk_next    = '0;
                qstep_next = '0;
                if (skip) begin
                    state_next = S_FIN;
                end else if (s_reg[47:16] == '0) begin
                    // zero distance: reciprocal clamps
                    sat_next   = 1'b1;
                    qa_next    = 64'(S64_MAX);
                    qb_next    = 64'(S64_MAX);
                    state_next = S_Q;
                end else begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                // r2_reg settles in S_CMP; kick the divider on entry
                if (qk_reg == 3'd0) begin
                    div_start = 1'b1;
                    qk_next   = 3'd1;
                end
                if (div_done) begin
                    qa_next    = 64'(div_q);
                    qb_next    = 64'(div_q);
                    qk_next    = '0;
                    state_next = S_Q;
                end
            end
            S_Q: begin
                if (mvalid_reg) begin
                    qacc_next = qacc_reg + pp_shifted;
                end
                if (qk_reg == 3'd4) begin
                    state_next = S_QEND;
                end else begin
                    qk_next = qk_reg + 3'd1;
                end
            end
            S_QEND: begin
                if (qm_sat) begin
                    sat_next = 1'b1;
                end
                qacc_next  = '0;
                qk_next    = '0;
                qstep_next = qstep_reg + 2'd1;
                case (qstep_reg)
                    2'd0: begin
                        qa_next    = qm_res;
                        state_next = S_Q;
                    end
                    2'd1: begin
                        inv3_next  = qm_res;
                        qa_next    = qm_res;
                        qb_next    = qm_res;
                        state_next = S_Q;
                    end
                    default: begin
                        e_next     = $signed(qm_res) - $signed(inv3_reg);
                        state_next = S_C2;
                    end
                endcase
            end
            S_C2: state_next = S_ADD1;
            S_ADD1: begin
                sa         = sat_add(e_reg, c2term);
                e_next     = sa[63:0];
                sat_next   = sat_reg | sa[64];
                state_next = S_ADD2;
            end
            S_ADD2: begin
                sa         = sat_add(e_reg, c0term);
                e_next     = sa[63:0];
                sat_next   = sat_reg | sa[64];
                state_next = S_DBL1;
            end
            S_DBL1: begin
                sa         = sat_add(e_reg, e_reg);
                e_next     = sa[63:0];
                sat_next   = sat_reg | sa[64];
                state_next = S_DBL2;
            end
            S_DBL2: begin
                sa         = sat_add(e_reg, e_reg);
                e_next     = sa[63:0];
                sat_next   = sat_reg | sa[64];
                state_next = S_ACC;
            end
            S_ACC: begin
                sa         = sat_add(acc_reg, e_acc);
                acc_next   = sa[63:0];
                sat_next   = sat_reg | sa[64];
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    res_valid  = 1'b1;
                    acc_next   = '0;
                    sat_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            acc_reg    <= '0;
            sat_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
            qk_reg     <= '0;
        end else begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            sat_reg    <= sat_next;
            mvalid_reg <= mvalid_next;
            qk_reg     <= qk_next;
        end
        ib_reg     <= ib_next;
        last_reg   <= last_next;
        ghost_reg  <= ghost_next;
        pa_reg     <= pa_next;
        dabs_reg   <= dabs_next;
        s_reg      <= s_next;
        r2_reg     <= r2_next;
        qa_reg     <= qa_next;
        qb_reg     <= qb_next;
        qacc_reg   <= qacc_next;
        qstep_reg  <= qstep_next;
        inv3_reg   <= inv3_next;
        e_reg      <= e_next;
        mul_reg    <= prod[63:0];
        mshift_reg <= mshift_next;
    end

    assign idle       = (state_reg == S_IDLE);
    assign res_energy = total;
    assign res_sat    = sat_reg;

endmodule

// ===== hw/rtl/lj_pair_energy_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// lj_pair_energy_accumulator_top
// Lennard-Jones pair energy with cutoff, fixed point, streamed pair list.
//
//   channel  | direction | contents
//   ---------+-----------+------------------------------------------------
//   s_       | in        | load position or process pair, tlast = last pair
//   m_       | out       | total energy Q32.32, tuser = saturation seen
//   cfg_     | in        | register writes: cutoff, c2, c0, real count, halve
//
// A load item is written straight into the position store and the block stays
// ready for the next item. A pair item is worked through before the next item
// is accepted, mostly in the bit-serial reciprocal (49 quotient bits) and the
// three 64x64 products, each built from 32x32 partial products on the one
// shared multiplier. A pair beyond the cutoff skips straight to the finish; a
// zero-distance pair skips the reciprocal.
// Reset clears the accumulator, the saturation flag and the registers; the
// position store is not cleared and must be loaded before use.
// One item at a time; a waiting result stalls only the final pair's finish.
// ----------------------------------------------------------------------------
module lj_pair_energy_accumulator_top
    import ljpe_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [119:0]           s_tdata,   // index_a, index_b, pos_x, pos_y, pos_z
    input  logic [0:0]             s_tuser,   // kind
    input  logic                   s_tlast,   // last_pair

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [63:0]            m_tdata,   // total_energy
    output logic [0:0]             m_tuser,   // saturated

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    ljpe_cfg_t   cfg_reg, cfg_next;
    ljpe_item_t  item;
    logic        core_idle;
    logic        start;
    logic        out_free;
    logic        res_valid;
    logic [63:0] res_energy;
    logic        res_sat;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg, m_data_next;
    logic        m_sat_reg, m_sat_next;

    // registers are always writable; write them only while the block is idle, which the block does not enforce
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CUTOFF_SQ:   cfg_next.cutoff_sq   = cfg_data;
                CFG_COEFF_C2:    cfg_next.coeff_c2    = cfg_data;
                CFG_COEFF_C0:    cfg_next.coeff_c0    = cfg_data;
                CFG_REAL_COUNT:  cfg_next.real_count  = cfg_data[12:0];
                CFG_FINAL_HALVE: cfg_next.final_halve = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // unpack the input item
    assign item.kind      = s_tuser[0];
    assign item.index_a   = s_tdata[11:0];
    assign item.index_b   = s_tdata[23:12];
    assign item.pos_x     = s_tdata[55:24];
    assign item.pos_y     = s_tdata[87:56];
    assign item.pos_z     = s_tdata[119:88];
    assign item.last_pair = s_tlast;

    assign s_tready = core_idle;
    assign start    = s_tvalid && core_idle;

    // output register: free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_tready;

    ljpe_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .start      (start),
        .item       (item),
        .idle       (core_idle),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res_energy (res_energy),
        .res_sat    (res_sat)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_sat_next   = m_sat_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = res_energy;
            m_sat_next   = res_sat;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_sat_reg  <= m_sat_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_sat_reg;

endmodule

// ===== tb/sv/tb_lj_pair_energy_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// tb_lj_pair_energy_accumulator_top
// Self-checking bench for the Lennard-Jones pair energy accumulator.
// Loads positions, streams pair lists under varied register settings and
// flow control, predicts every energy total and compares each result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lj_pair_energy_accumulator_top
    import ljpe_pkg::*;
();

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;  // no register here
    localparam int WATCHDOG_LIMIT = 6000;   // long hold-off plus a pair or two
    localparam int SETTLE_CYCLES  = 120;    // long enough for a trailing pair to finish
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic signed [63:0] total;
        logic               sat;
    } energy_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [119:0]           s_tdata = '0;    // index_a, index_b, pos_x, pos_y, pos_z
    logic [0:0]             s_tuser = '0;    // kind
    logic                   s_tlast = 1'b0;  // last_pair
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [63:0]            m_tdata;         // total_energy
    logic [0:0]             m_tuser;         // saturated
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data = '0;

    always #2 aclk = ~aclk;

    lj_pair_energy_accumulator_top u_dut (.*);

    // ---- predictor state: its own copy of the store, registers and sums ----
    logic [31:0]        pos_x_mem [MAX_PARTICLES];
    logic [31:0]        pos_y_mem [MAX_PARTICLES];
    logic [31:0]        pos_z_mem [MAX_PARTICLES];
    int                 loaded_idx[$];       // indices written so far
    bit                 loaded_map [MAX_PARTICLES];
    logic signed [63:0] energy_sum;
    bit                 sat_flag;
    logic [31:0]        r_cutoff;
    logic signed [31:0] r_c2, r_c0;
    logic [12:0]        r_real;
    logic               r_halve;

    energy_result_t     energy_q[$];         // totals still to come out
    int                 errors = 0;
    int                 idle_pct = 0;        // sender gap chance, percent
    int                 stall_pct = 0;       // receiver stall chance, percent
    int                 hold_cycles = 0;     // long receiver hold-off
    int                 quiet_cycles = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // saturating signed add, flags any clamp
    function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(S64_MAX)) begin
            sat_flag = 1'b1;
            return S64_MAX;
        end
        if (s < 65'(S64_MIN)) begin
            sat_flag = 1'b1;
            return S64_MIN;
        end
        return s[63:0];
    endfunction

    // Q32.32 product of non-negatives, clamped to 2^63-1
    function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        if (p[127:95] != '0) begin
            sat_flag = 1'b1;
            return S64_MAX;
        end
        return p[95:32];
    endfunction

    function automatic void pair_energy(input logic [11:0] ia, input logic [11:0] ib);
        logic signed [32:0] dx, dy, dz;
        logic [67:0]        dist_sq;
        logic [31:0]        r2;
        logic [63:0]        recip, p3, p6;
        logic signed [64:0] c2r2;
        logic signed [63:0] e;
        dx = 33'($signed(pos_x_mem[ia])) - 33'($signed(pos_x_mem[ib]));
        dy = 33'($signed(pos_y_mem[ia])) - 33'($signed(pos_y_mem[ib]));
        dz = 33'($signed(pos_z_mem[ia])) - 33'($signed(pos_z_mem[ib]));
        dist_sq = 68'(66'(dx * dx)) + 68'(66'(dy * dy)) + 68'(66'(dz * dz));
        if (dist_sq >= (68'd1 << 48)) return;     // beyond any cutoff
        r2 = dist_sq[47:16];
        if (r2 > r_cutoff) return;
        if (r2 == 0) begin
            sat_flag = 1'b1;
            recip = S64_MAX;
        end else begin
            recip = (64'd1 << 48) / 64'(r2);
        end
        p3 = q_mul(q_mul(recip, recip), recip);
        p6 = q_mul(p3, p3);
        e = $signed(p6) - $signed(p3);
        c2r2 = 65'(r_c2) * $signed({33'd0, r2});
        e = sat_sum(e, 64'(c2r2 >>> 8));
        e = sat_sum(e, 64'(r_c0) <<< 8);
        e = sat_sum(e, e);
        e = sat_sum(e, e);
        if ({1'b0, ia} >= r_real || {1'b0, ib} >= r_real) e = e >>> 1;  // ghost
        energy_sum = sat_sum(energy_sum, e);
    endfunction

    // apply one accepted item to the predictor
    function automatic void predict_item(input logic kind, input logic [11:0] ia,
                                         input logic [11:0] ib, input logic [31:0] px,
                                         input logic [31:0] py, input logic [31:0] pz,
                                         input logic last);
        energy_result_t r;
        if (kind == KIND_LOAD) begin
            pos_x_mem[ia] = px;
            pos_y_mem[ia] = py;
            pos_z_mem[ia] = pz;
            if (!loaded_map[ia]) loaded_idx.push_back(ia);
            loaded_map[ia] = 1'b1;
            return;
        end
        pair_energy(ia, ib);
        if (!last) return;
        r.total = r_halve ? (energy_sum >>> 1) : energy_sum;
        r.sat = sat_flag;
        energy_q.push_back(r);
        energy_sum = '0;
        sat_flag = 1'b0;
    endfunction

    // ---- drivers ----
    task automatic send_item(input logic kind, input logic [11:0] ia, input logic [11:0] ib,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic last);
        int gap;
        gap = 0;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= {pz, py, px, ib, ia};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(kind, ia, ib, px, py, pz, last);
        @(negedge aclk);
    endtask

    task automatic stop_items();
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_pos(input logic [11:0] ia, input logic [31:0] px,
                            input logic [31:0] py, input logic [31:0] pz);
        send_item(KIND_LOAD, ia, 12'($urandom), px, py, pz, 1'($urandom));
    endtask

    task automatic send_pair(input logic [11:0] ia, input logic [11:0] ib, input logic last);
        send_item(KIND_PAIR, ia, ib, $urandom, $urandom, $urandom, last);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_CUTOFF_SQ:   r_cutoff = val;
            CFG_COEFF_C2:    r_c2 = val;
            CFG_COEFF_C0:    r_c0 = val;
            CFG_REAL_COUNT:  r_real = val[12:0];
            CFG_FINAL_HALVE: r_halve = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_regs(input logic [31:0] cut, input logic [31:0] c2,
                            input logic [31:0] c0, input logic [12:0] cnt,
                            input logic halve);
        write_reg(CFG_CUTOFF_SQ, cut);
        write_reg(CFG_COEFF_C2, c2);
        write_reg(CFG_COEFF_C0, c0);
        write_reg(CFG_REAL_COUNT, 32'(cnt));
        write_reg(CFG_FINAL_HALVE, 32'(halve));
    endtask

    // everything out, then let a trailing pair with no result finish
    task automatic drain();
        stop_items();
        while (energy_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ---- receiver: random stalls, plus a counted hold-off when asked ----
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    // ---- result checker ----
    always @(posedge aclk) begin
        energy_result_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (energy_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, '0);
            end else begin
                w = energy_q.pop_front();
                if (m_tdata !== w.total) report_mismatch("total_energy", m_tdata, w.total);
                if (m_tuser[0] !== w.sat) report_mismatch("saturated", 64'(m_tuser), 64'(w.sat));
            end
        end
    end

    // ---- watchdog: cycles with no handshake anywhere ----
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // random position: mostly a tight cluster so pairs fall inside the cutoff
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(7) == 0) return $urandom;
        return 32'($signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000);
    endfunction

    function automatic logic [11:0] pick_loaded();
        return 12'(loaded_idx[$urandom_range(loaded_idx.size() - 1)]);
    endfunction

    // ---- tests ----
    task automatic test_directed();
        set_regs(32'hFFFF_FFFF, 32'sh0100_0000, 32'shFF00_0000, 13'd4, 1'b0);
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);              // ignored
        load_pos(12'd0, 32'h0, 32'h0, 32'h0);
        load_pos(12'd1, 32'h0001_0000, 32'h0, 32'h0);      // unit distance
        load_pos(12'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        load_pos(12'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        load_pos(12'hFFF, 32'h0000_8000, 32'h0, 32'h0);    // half unit, ghost
        load_pos(12'd5, 32'h0000_0100, 32'h0, 32'h0);      // r2 of one lsb
        send_pair(12'd0, 12'd1, 1'b0);
        send_pair(12'd0, 12'hFFF, 1'b0);                   // ghost halving
        send_pair(12'd0, 12'd0, 1'b1);                     // zero distance
        send_pair(12'd2, 12'd3, 1'b1);                     // out of range, skipped last
        send_pair(12'd0, 12'd5, 1'b1);                     // reciprocal powers clamp
        send_item(KIND_LOAD, 12'd6, 12'hFFF, 32'h0000_4000, 32'h0000_4000, 32'h0, 1'b1);
        send_pair(12'd6, 12'd1, 1'b0);
        send_pair(12'hFFF, 12'd6, 1'b1);
        drain();
        set_regs(32'h0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 13'd4096, 1'b1);
        send_pair(12'd0, 12'd1, 1'b0);                     // beyond zero cutoff
        send_pair(12'd0, 12'd0, 1'b1);                     // r2 of zero still inside
        send_pair(12'd0, 12'd5, 1'b1);
        drain();
    endtask

    task automatic test_random(input int n_items, input logic [31:0] cut,
                               input logic [31:0] c2, input logic [31:0] c0,
                               input logic [12:0] cnt, input logic halve);
        int sent, run_len;
        set_regs(cut, c2, c0, cnt, halve);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 2 || loaded_idx.size() < 8) begin
                load_pos(12'($urandom), rand_coord(), rand_coord(), rand_coord());
                sent++;
            end else begin
                // one pair list ending on a marked last pair
                run_len = $urandom_range(1, 10);
                for (int k = 0; k < run_len; k++) begin
                    send_pair(pick_loaded(), pick_loaded(), k == run_len - 1);
                    sent++;
                end
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_cycles = 900;
        for (int k = 0; k < 40; k++)
            send_pair(pick_loaded(), pick_loaded(), $urandom_range(2) == 0);
        send_pair(pick_loaded(), pick_loaded(), 1'b1);
        drain();
    endtask

    initial begin
        energy_sum = '0;
        sat_flag = 1'b0;
        r_cutoff = '0; r_c2 = '0; r_c0 = '0; r_real = '0; r_halve = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();

        idle_pct = 0;  stall_pct = 0;
        test_random(330, 32'h0009_0000, 32'($urandom),
                    32'($signed(32'($urandom_range(0, 32'h0200_0000))) - 32'sh0100_0000),
                    13'($urandom_range(0, 4096)), 1'b0);
        idle_pct = 66; stall_pct = 0;
        test_random(330, 32'hFFFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 13'd0, 1'b1);
        idle_pct = 0;  stall_pct = 66;
        test_random(330, 32'($urandom_range(0, 32'h0010_0000)), 32'sh0000_4000,
                    32'sh7FFF_FFFF, 13'd4096, 1'b0);
        idle_pct = 7;  stall_pct = 7;
        test_random(300, 32'h0004_0000, 32'($urandom), 32'($urandom),
                    13'($urandom_range(0, 4096)), 1'b1);

        idle_pct = 0;  stall_pct = 0;
        test_backpressure();

        if (energy_q.size() != 0) report_mismatch("results missing", 64'(energy_q.size()), '0);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
